### src/srcg_pkg.sv
// package for the strided region chunk generator
// holds widths, register indexes, axis setup and the structs shared by the modules
// no dependencies
package srcg_pkg;

   // field widths
   localparam int CNT_W      = 11;
   localparam int NB_W       = 7;
   localparam int START_W    = 10;
   localparam int CAP_W      = 32;
   localparam int OFS_W      = 36;
   localparam int SIZE_W     = 37;
   localparam int INNER_W    = 31;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // axis setup
   localparam bit HAVE_X         = 1'b1;
   localparam bit HAVE_Y         = 1'b1;
   localparam bit HAVE_Z         = 1'b1;
   localparam int MAX_AXIS_NODES = 1024;
   localparam int MAX_NODE_BYTES = 64;
   localparam int LIMIT_W        = 17;

   // place of each present axis in the merge list, fastest first
   localparam int POS_Z     = 0;
   localparam int POS_Y     = int'(HAVE_Z);
   localparam int POS_X     = int'(HAVE_Z) + int'(HAVE_Y);
   localparam int NPRES     = int'(HAVE_Z) + int'(HAVE_Y) + int'(HAVE_X);
   localparam int ENT_DEPTH = 6;

   // divider: four quotient bits per cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = CAP_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ARRAY_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ARRAY_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ARRAY_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_BYTES = 3'd6;

   // request kinds
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0] array_x;
      logic [CNT_W-1:0] array_y;
      logic [CNT_W-1:0] array_z;
      logic [CNT_W-1:0] box_x;
      logic [CNT_W-1:0] box_y;
      logic [CNT_W-1:0] box_z;
      logic [NB_W-1:0]  node_bytes;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic start_commit;
      logic next_commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_next;
      logic div_done;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [CNT_W-1:0]   cnt;
      logic [INNER_W-1:0] nodes;
      logic [SIZE_W-1:0]  stride;
      logic               eq;
   } entry_type;

endpackage

### src/srcg_div.sv
// iterative divider of a capacity by the node size, four bits per cycle
// depends on srcg_pkg
module srcg_div
   import srcg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CAP_W-1:0]   dividend,
   input  logic [NB_W-1:0]    divisor,
   output logic               done,
   output logic [CAP_W-1:0]   quotient,
   output logic [NB_W-1:0]    remainder
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CAP_W-1:0]     quo_ff, quo_in;
   logic [NB_W-1:0]      rem_ff, rem_in;
   logic [NB_W-1:0]      dvs_ff, dvs_in;
   logic [CAP_W-1:0]     q_step;
   logic [NB_W-1:0]      r_step;

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   // restoring steps for one cycle
   always_comb begin
      logic [NB_W:0] t;
      q_step = quo_ff;
      r_step = rem_ff;
      t      = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         t      = {r_step, q_step[CAP_W-1]};
         q_step = {q_step[CAP_W-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            t         = t - {1'b0, dvs_ff};
            q_step[0] = 1'b1;
         end
         r_step = t[NB_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = q_step;
         rem_in  = r_step;
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != CNT_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = busy_ff && (cnt_ff == CNT_LAST);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### src/srcg_dp.sv
// datapath: box check, stride products, axis merge, cursor and result register
// depends on srcg_pkg and srcg_div
module srcg_dp
   import srcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   // captured request
   logic               kind_ff;
   logic [START_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [CAP_W-1:0]   cap_ff;

   // start pipeline
   logic        bad_ff, bad_in;
   logic [21:0] nyz_ff, nyz_in;
   logic [17:0] sty_ff, sty_in;
   logic [21:0] inn_y_ff, inn_y_in;
   logic [32:0] nxyz_ff, nxyz_in;
   logic [28:0] stx_ff, stx_in;
   logic [16:0] pz_ff, pz_in;
   logic [27:0] py_ff, py_in;
   logic [32:0] inn_x_ff, inn_x_in;
   logic [39:0] total_full;
   logic [38:0] px_full;
   logic [SIZE_W-1:0] total_ff;
   logic [OFS_W-1:0]  px_ff;

   // transfer state
   logic [CNT_W-1:0]   oi_ff, oi_in, mi_ff, mi_in, oc_ff, oc_in, mc_ff, mc_in;
   logic [INNER_W-1:0] done_ff, done_in, ic_ff, ic_in;
   logic [SIZE_W-1:0]  os_ff, os_in, ms_ff, ms_in;
   logic [OFS_W-1:0]   mid_ff, mid_in, row_ff, row_in, cur_ff, cur_in;
   logic [NB_W-1:0]    nbh_ff, nbh_in;
   logic               fin_ff, fin_in;

   // chunk arithmetic
   logic [INNER_W-1:0] left_ff;
   logic [37:0]        lbytes_full;
   logic [SIZE_W-1:0]  lbytes_ff;

   // result register
   logic                  vld_ff, vld_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  last_ff, last_in, user_ff, user_in;

   logic [CNT_W-1:0]   ax, ay, az, bx, by, bz;
   logic [START_W-1:0] sx, sy, sz;
   logic [NB_W-1:0]    nb;
   logic [OFS_W-1:0]   origin;
   entry_type          ent [0:ENT_DEPTH-1];
   entry_type          e_in, e_md, e_ot;
   logic [1:0]         merge_g;
   logic               div_done;
   logic [CAP_W-1:0]   quo;
   logic [NB_W-1:0]    rem;

   localparam logic [LIMIT_W-1:0] AXIS_LIMIT = LIMIT_W'(MAX_AXIS_NODES);
   localparam logic [NB_W-1:0]    NB_LIMIT   = NB_W'(MAX_NODE_BYTES);

   function automatic logic axis_bad(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                     logic [START_W-1:0] s);
      logic [CNT_W:0] reach;
      reach = {2'b00, s} + {1'b0, b};
      return (a == '0) || (b == '0) ||
             ({6'b0, a} > AXIS_LIMIT) || ({6'b0, b} > AXIS_LIMIT) ||
             (reach > {1'b0, a});
   endfunction

   // absent axes read as one node, start zero
   assign ax = HAVE_X ? cfg.array_x : CNT_W'(1);
   assign ay = HAVE_Y ? cfg.array_y : CNT_W'(1);
   assign az = HAVE_Z ? cfg.array_z : CNT_W'(1);
   assign bx = HAVE_X ? cfg.box_x : CNT_W'(1);
   assign by = HAVE_Y ? cfg.box_y : CNT_W'(1);
   assign bz = HAVE_Z ? cfg.box_z : CNT_W'(1);
   assign sx = HAVE_X ? sx_ff : '0;
   assign sy = HAVE_Y ? sy_ff : '0;
   assign sz = HAVE_Z ? sz_ff : '0;
   assign nb = cfg.node_bytes;

   // start stage one
   assign bad_in = (nb == '0) || (nb > NB_LIMIT) ||
                   (HAVE_X && axis_bad(cfg.array_x, cfg.box_x, sx_ff)) ||
                   (HAVE_Y && axis_bad(cfg.array_y, cfg.box_y, sy_ff)) ||
                   (HAVE_Z && axis_bad(cfg.array_z, cfg.box_z, sz_ff));
   assign nyz_in   = {11'b0, ay} * {11'b0, az};
   assign sty_in   = {11'b0, nb} * {7'b0, az};
   assign inn_y_in = {11'b0, by} * {11'b0, az};

   // start stage two
   assign nxyz_in  = {22'b0, ax} * {11'b0, nyz_ff};
   assign stx_in   = {22'b0, nb} * {7'b0, nyz_ff};
   assign pz_in    = {7'b0, sz} * {10'b0, nb};
   assign py_in    = {18'b0, sy} * {10'b0, sty_ff};
   assign inn_x_in = {22'b0, bx} * {11'b0, nyz_ff};

   // start stage three
   assign total_full = {33'b0, nb} * {7'b0, nxyz_ff};
   assign px_full    = {29'b0, sx} * {10'b0, stx_ff};

   always_ff @(posedge clock) begin
      bad_ff   <= bad_in;
      nyz_ff   <= nyz_in;
      sty_ff   <= sty_in;
      inn_y_ff <= inn_y_in;
      nxyz_ff  <= nxyz_in;
      stx_ff   <= stx_in;
      pz_ff    <= pz_in;
      py_ff    <= py_in;
      inn_x_ff <= inn_x_in;
      total_ff <= total_full[SIZE_W-1:0];
      px_ff    <= px_full[OFS_W-1:0];
      left_ff  <= ic_ff - done_ff;
      lbytes_ff <= lbytes_full[SIZE_W-1:0];
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         sx_ff   <= req_tdata[9:0];
         sy_ff   <= req_tdata[19:10];
         sz_ff   <= req_tdata[29:20];
         cap_ff  <= req_tdata[61:30];
      end
   end

   assign lbytes_full = {7'b0, left_ff} * {31'b0, nbh_ff};
   assign origin = px_ff + {8'b0, py_ff} + {19'b0, pz_ff};

   // merge list: present axes fastest first, then the whole array
   always_comb begin
      for (int i = 0; i < ENT_DEPTH; i++) begin
         ent[i] = '0;
      end
      if (HAVE_Z) begin
         ent[POS_Z] = '{cnt: bz, nodes: {20'b0, bz}, stride: {30'b0, nb},
                        eq: (cfg.box_z == cfg.array_z)};
      end
      if (HAVE_Y) begin
         ent[POS_Y] = '{cnt: by, nodes: {9'b0, inn_y_ff}, stride: {19'b0, sty_ff},
                        eq: (cfg.box_y == cfg.array_y)};
      end
      if (HAVE_X) begin
         ent[POS_X] = '{cnt: bx, nodes: inn_x_ff[INNER_W-1:0], stride: {8'b0, stx_ff},
                        eq: (cfg.box_x == cfg.array_x)};
      end
      ent[NPRES] = '{cnt: CNT_W'(1), nodes: nxyz_ff[INNER_W-1:0], stride: total_ff,
                     eq: 1'b0};
   end

   // leading axes that span the whole array fold into the inner run
   always_comb begin
      merge_g = 2'd0;
      if (ent[0].eq) begin
         merge_g = 2'd1;
         if (ent[1].eq) begin
            merge_g = 2'd2;
            if (ent[2].eq) begin
               merge_g = 2'd3;
            end
         end
      end
   end

   always_comb begin
      case (merge_g)
         2'd0: begin
            e_in = ent[0]; e_md = ent[1]; e_ot = ent[2];
         end
         2'd1: begin
            e_in = ent[1]; e_md = ent[2]; e_ot = ent[3];
         end
         2'd2: begin
            e_in = ent[2]; e_md = ent[3]; e_ot = ent[4];
         end
         default: begin
            e_in = ent[3]; e_md = ent[4]; e_ot = ent[5];
         end
      endcase
   end

   srcg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cap_ff),
      .divisor   (nbh_ff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // cursor update and result
   always_comb begin
      logic [SIZE_W-1:0] size;
      logic [CAP_W-1:0]  part;
      logic [CNT_W-1:0]  mi_next, oi_next;
      logic [OFS_W-1:0]  mid_next;
      oi_in   = oi_ff;   mi_in  = mi_ff;   done_in = done_ff;
      oc_in   = oc_ff;   mc_in  = mc_ff;   ic_in   = ic_ff;
      os_in   = os_ff;   ms_in  = ms_ff;
      mid_in  = mid_ff;  row_in = row_ff;  cur_in  = cur_ff;
      nbh_in  = nbh_ff;  fin_in = fin_ff;
      data_in = data_ff; last_in = last_ff; user_in = user_ff;
      vld_in  = vld_ff && !rsp_tready;
      size     = '0;
      part     = cap_ff - {25'b0, rem};
      mi_next  = mi_ff + 1'b1;
      oi_next  = oi_ff + 1'b1;
      mid_next = mid_ff + os_ff[OFS_W-1:0];

      if (cmd.start_commit) begin
         vld_in  = 1'b1;
         oi_in   = '0;
         mi_in   = '0;
         done_in = '0;
         if (bad_ff) begin
            fin_in  = 1'b1;
            mid_in  = '0;
            row_in  = '0;
            cur_in  = '0;
            data_in = '0;
            last_in = 1'b1;
            user_in = 1'b1;
         end else begin
            fin_in  = 1'b0;
            ic_in   = e_in.nodes;
            mc_in   = e_md.cnt;
            ms_in   = e_md.stride;
            oc_in   = e_ot.cnt;
            os_in   = e_ot.stride;
            nbh_in  = nb;
            mid_in  = origin;
            row_in  = origin;
            cur_in  = origin;
            data_in = {7'b0, SIZE_W'(0), origin};
            last_in = 1'b0;
            user_in = 1'b0;
         end
      end

      if (cmd.next_commit) begin
         vld_in  = 1'b1;
         user_in = 1'b0;
         if (fin_ff) begin
            data_in = '0;
            last_in = 1'b1;
         end else begin
            if ({5'b0, cap_ff} >= lbytes_ff) begin
               // whole rest of the run fits
               size    = lbytes_ff;
               done_in = '0;
               if (mi_next >= mc_ff) begin
                  mi_in  = '0;
                  oi_in  = oi_next;
                  mid_in = mid_next;
                  row_in = mid_next;
                  cur_in = mid_next;
                  if (oi_next >= oc_ff) begin
                     fin_in = 1'b1;
                  end
               end else begin
                  mi_in  = mi_next;
                  row_in = row_ff + ms_ff[OFS_W-1:0];
                  cur_in = row_ff + ms_ff[OFS_W-1:0];
               end
            end else begin
               // whole nodes that fit in the buffer
               size    = {5'b0, part};
               done_in = done_ff + quo[INNER_W-1:0];
               cur_in  = cur_ff + {4'b0, part};
            end
            data_in = {7'b0, size, cur_ff};
            last_in = fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oi_ff   <= '0;
         mi_ff   <= '0;
         done_ff <= '0;
         oc_ff   <= '0;
         mc_ff   <= '0;
         ic_ff   <= '0;
         os_ff   <= '0;
         ms_ff   <= '0;
         mid_ff  <= '0;
         row_ff  <= '0;
         cur_ff  <= '0;
         nbh_ff  <= '0;
         fin_ff  <= 1'b1;
         vld_ff  <= 1'b0;
      end else begin
         oi_ff   <= oi_in;
         mi_ff   <= mi_in;
         done_ff <= done_in;
         oc_ff   <= oc_in;
         mc_ff   <= mc_in;
         ic_ff   <= ic_in;
         os_ff   <= os_in;
         ms_ff   <= ms_in;
         mid_ff  <= mid_in;
         row_ff  <= row_in;
         cur_ff  <= cur_in;
         nbh_ff  <= nbh_in;
         fin_ff  <= fin_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign status.is_next  = (kind_ff == CMD_NEXT);
   assign status.div_done = div_done;
   assign status.out_free = !vld_ff || rsp_tready;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

### src/srcg_ctrl.sv
// controller: sequences start and next requests over the datapath
// depends on srcg_pkg
module srcg_ctrl
   import srcg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_SMUL2   = 3'd2;
   localparam logic [2:0] ST_SMUL3   = 3'd3;
   localparam logic [2:0] ST_SCOMMIT = 3'd4;
   localparam logic [2:0] ST_NDIV    = 3'd5;
   localparam logic [2:0] ST_NCOMMIT = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_next) begin
               cmd.div_start = 1'b1;
               state_in      = ST_NDIV;
            end else begin
               state_in = ST_SMUL2;
            end
         end
         ST_SMUL2: begin
            state_in = ST_SMUL3;
         end
         ST_SMUL3: begin
            state_in = ST_SCOMMIT;
         end
         ST_SCOMMIT: begin
            if (status.out_free) begin
               cmd.start_commit = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_NDIV: begin
            if (status.div_done) begin
               state_in = ST_NCOMMIT;
            end
         end
         ST_NCOMMIT: begin
            if (status.out_free) begin
               cmd.next_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### src/strided_region_chunk_generator_unit.sv
// top level of the strided region chunk generator: register file, controller, datapath
// depends on srcg_pkg, srcg_ctrl, srcg_dp (and srcg_div below it)
//
//   channel   direction  handshake            payload
//   req       in         req_tvalid/tready    tdata starts and capacity, tuser kind
//   rsp       out        rsp_tvalid/tready    tdata offset and size, tlast done, tuser error
//   csr       in         csr_we               csr_index, csr_wdata
//
// a start request passes the accept state, a decode and box check state, the stride
//   multiply states SMUL2 and SMUL3, and a merge and commit state
// a next request starts the divider of capacity by node size in its decode state and
//   waits for it, at four quotient bits per cycle, before its commit state
// reset is synchronous; after it the block is done, with zero offsets and sizes
// a result waits in the output register while rsp_tready is low; the next
//   request is accepted meanwhile and holds in its commit cycle until the slot frees
module strided_region_chunk_generator_unit
   import srcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // box_start_x, box_start_y, box_start_z,
                                             // buffer_capacity, zero fill
   input  logic                  req_tuser,  // cmd
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // chunk_offset, chunk_size, zero fill
   output logic                  rsp_tlast,  // all_done
   output logic                  rsp_tuser,  // box_error
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;

   // register file, values kept as written (masked to register width)
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ARRAY_X:    cfg_in.array_x    = csr_wdata;
            REG_ARRAY_Y:    cfg_in.array_y    = csr_wdata;
            REG_ARRAY_Z:    cfg_in.array_z    = csr_wdata;
            REG_BOX_X:      cfg_in.box_x      = csr_wdata;
            REG_BOX_Y:      cfg_in.box_y      = csr_wdata;
            REG_BOX_Z:      cfg_in.box_z      = csr_wdata;
            REG_NODE_BYTES: cfg_in.node_bytes = csr_wdata[NB_W-1:0];
            default: begin
               // index beyond the list, ignored
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.array_x    <= CNT_W'(1);
         cfg_ff.array_y    <= CNT_W'(1);
         cfg_ff.array_z    <= CNT_W'(1);
         cfg_ff.box_x      <= CNT_W'(1);
         cfg_ff.box_y      <= CNT_W'(1);
         cfg_ff.box_z      <= CNT_W'(1);
         cfg_ff.node_bytes <= NB_W'(8);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   srcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // box check, strides, cursor and output register
   srcg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### tb/strided_region_chunk_generator_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for strided_region_chunk_generator_unit: directed and random box
// transfers, chunks predicted by a cycle-free walker and checked in order
// depends on srcg_pkg and the rtl
module strided_region_chunk_generator_unit_test
   import srcg_pkg::*;
();

   localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake or register write before giving up
   localparam int SETTLE_TAIL  = 16;    // longer than a next request
   localparam int RANDOM_ITEMS = 550;
   localparam int NEXT_BUDGET  = 24;    // next requests per transfer before moving on

   // one request as the bench sees it; hold makes the driver wait for every response first
   typedef struct packed {
      logic               hold;
      logic               cmd;
      logic [START_W-1:0] start_x;
      logic [START_W-1:0] start_y;
      logic [START_W-1:0] start_z;
      logic [CAP_W-1:0]   capacity;
   } box_req_type;

   typedef struct packed {
      logic [OFS_W-1:0]  offset;
      logic [SIZE_W-1:0] size;
      logic              done;
      logic              err;
   } chunk_type;

   // register copy plus the chunk cursor of the running transfer
   typedef struct packed {
      logic [CNT_W-1:0]   arr_x, arr_y, arr_z, box_x, box_y, box_z;
      logic [NB_W-1:0]    node_bytes;
      logic [NB_W-1:0]    held_bytes;
      logic [CNT_W-1:0]   outer_idx, middle_idx, outer_cnt, middle_cnt;
      logic [INNER_W-1:0] inner_done, inner_cnt;
      logic [SIZE_W-1:0]  outer_stride, middle_stride;
      logic [OFS_W-1:0]   origin;
      logic               done;
   } walker_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = CMD_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_ARRAY_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   box_req_type req_backlog[$];  // requests waiting for the driver
   chunk_type   chunks_due[$];   // predicted responses, oldest first
   walker_type  live_walk;       // advanced on each accepted request
   walker_type  shadow_walk;     // advanced as requests are planned, steers the stimulus
   box_req_type cur;
   int          req_wait = 0;
   int          rsp_wait = 0;
   int          in_flight = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          posted = 0;
   bit          req_idle = 1'b1;
   bit          rsp_idle = 1'b1;

   strided_region_chunk_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // box_start_x, box_start_y, box_start_z, buffer_capacity
      .req_tuser  (req_tuser),   // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // chunk_offset, chunk_size
      .rsp_tlast  (rsp_tlast),   // all_done
      .rsp_tuser  (rsp_tuser),   // box_error
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic walker_type fresh_walker();
      walker_type w;
      w = '0;
      w.arr_x = CNT_W'(1);
      w.arr_y = CNT_W'(1);
      w.arr_z = CNT_W'(1);
      w.box_x = CNT_W'(1);
      w.box_y = CNT_W'(1);
      w.box_z = CNT_W'(1);
      w.node_bytes = NB_W'(8);
      w.done = 1'b1;  // nothing to transfer until a start
      return w;
   endfunction

   function automatic void load_reg(inout walker_type w, input logic [CSR_IDX_W-1:0] idx,
                                    input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_ARRAY_X:    w.arr_x = val;
         REG_ARRAY_Y:    w.arr_y = val;
         REG_ARRAY_Z:    w.arr_z = val;
         REG_BOX_X:      w.box_x = val;
         REG_BOX_Y:      w.box_y = val;
         REG_BOX_Z:      w.box_z = val;
         REG_NODE_BYTES: w.node_bytes = val[NB_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic bit axis_misfit(logic [CNT_W-1:0] whole, logic [CNT_W-1:0] span,
                                      logic [START_W-1:0] first);
      return int'(whole) == 0 || int'(span) == 0 || int'(whole) > MAX_AXIS_NODES ||
             int'(span) > MAX_AXIS_NODES || int'(first) + int'(span) > int'(whole);
   endfunction

   // response to one request; moves the cursor of w
   function automatic chunk_type walk_chunk(inout walker_type w, input box_req_type r);
      chunk_type   c;
      logic [63:0] nb, ofs, left, cap, nodes;
      logic [63:0] len [6];
      logic [63:0] pitch [6];
      int          g;
      bit          bad;
      c = '0;
      if (r.cmd == CMD_START) begin
         nb = 64'(w.node_bytes);
         bad = nb == 64'd0 || nb > 64'(MAX_NODE_BYTES) ||
               axis_misfit(w.arr_x, w.box_x, r.start_x) ||
               axis_misfit(w.arr_y, w.box_y, r.start_y) ||
               axis_misfit(w.arr_z, w.box_z, r.start_z);
         w.outer_idx = '0;
         w.middle_idx = '0;
         w.inner_done = '0;
         if (bad) begin
            w.done = 1'b1;
            w.origin = '0;
            c.err = 1'b1;
         end else begin
            // axis list fastest first, closed by the whole array as one span
            len = '{64'(w.box_z), 64'(w.box_y), 64'(w.box_x), 64'd1, 64'd0, 64'd0};
            pitch[0] = nb;
            pitch[1] = pitch[0] * 64'(w.arr_z);
            pitch[2] = pitch[1] * 64'(w.arr_y);
            pitch[3] = pitch[2] * 64'(w.arr_x);
            pitch[4] = 64'd0;
            pitch[5] = 64'd0;
            w.origin = OFS_W'(64'(r.start_x) * pitch[2] + 64'(r.start_y) * pitch[1] +
                              64'(r.start_z) * pitch[0]);
            // an axis whose span covers its whole pitch folds into the next one
            g = 0;
            repeat (3)
               if (g < 3 && pitch[g] * len[g] == pitch[g + 1]) g++;
            w.inner_cnt = INNER_W'(len[g] * (pitch[g] / nb));
            w.middle_cnt = CNT_W'(len[g + 1]);
            w.middle_stride = SIZE_W'(pitch[g + 1]);
            w.outer_cnt = CNT_W'(len[g + 2]);
            w.outer_stride = SIZE_W'(pitch[g + 2]);
            w.held_bytes = w.node_bytes;
            w.done = 1'b0;
         end
         c.offset = w.origin;
         c.done = w.done;
      end else begin
         c.done = 1'b1;
         if (!w.done && w.held_bytes != '0) begin
            nb = 64'(w.held_bytes);
            cap = 64'(r.capacity);
            ofs = 64'(w.origin) + 64'(w.outer_idx) * 64'(w.outer_stride) +
                  64'(w.middle_idx) * 64'(w.middle_stride) + 64'(w.inner_done) * nb;
            left = (w.inner_cnt > w.inner_done) ? 64'(w.inner_cnt - w.inner_done) : 64'd0;
            if (cap >= left * nb) begin
               c.size = SIZE_W'(left * nb);
               w.inner_done = '0;
               w.middle_idx++;
               if (w.middle_idx >= w.middle_cnt) begin
                  w.middle_idx = '0;
                  w.outer_idx++;
                  if (w.outer_idx >= w.outer_cnt) w.done = 1'b1;
               end
            end else begin
               nodes = cap / nb;
               w.inner_done = w.inner_done + INNER_W'(nodes);
               c.size = SIZE_W'(nodes * nb);
            end
            c.offset = OFS_W'(ofs);
            c.done = w.done;
         end
      end
      return c;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   task automatic push(input logic cmd, input logic [START_W-1:0] sx,
                       input logic [START_W-1:0] sy, input logic [START_W-1:0] sz,
                       input logic [CAP_W-1:0] cap, input bit hold);
      box_req_type r;
      r = '{hold: hold, cmd: cmd, start_x: sx, start_y: sy, start_z: sz, capacity: cap};
      void'(walk_chunk(shadow_walk, r));
      req_backlog.push_back(r);
      posted++;
   endtask

   // wait until every request has been answered, then let the block go quiet
   task automatic settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || chunks_due.size() != 0);
      req_idle = $urandom_range(0, 3) != 0;
      rsp_idle = $urandom_range(0, 3) != 0;
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   task automatic set_config(input int ax, input int ay, input int az, input int bx,
                             input int by, input int bz, input int nb);
      logic [CSR_IDX_W-1:0] slot [7];
      int                   value [7];
      int                   k;
      slot = '{REG_ARRAY_X, REG_ARRAY_Y, REG_ARRAY_Z, REG_BOX_X, REG_BOX_Y, REG_BOX_Z,
               REG_NODE_BYTES};
      value = '{ax, ay, az, bx, by, bz, nb};
      settle();
      for (k = 0; k < 7; k++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= slot[k];
         csr_wdata <= value[k][CSR_DATA_W-1:0];
         load_reg(live_walk, slot[k], value[k][CSR_DATA_W-1:0]);
         load_reg(shadow_walk, slot[k], value[k][CSR_DATA_W-1:0]);
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // capacities cluster around what is left of the current run
   function automatic logic [CAP_W-1:0] pick_capacity(walker_type w);
      logic [63:0] rest, pick;
      rest = 64'(w.inner_cnt - w.inner_done) * 64'(w.held_bytes);
      case ($urandom_range(0, 9))
         0, 1, 2: pick = rest;
         3:       pick = rest + 64'($urandom_range(1, MAX_NODE_BYTES));
         4, 5:    pick = (rest == 64'd0) ? 64'd0 : {$urandom, $urandom} % rest;
         6:       pick = (w.held_bytes > NB_W'(1)) ?
                         64'($urandom_range(0, int'(w.held_bytes) - 1)) : 64'd0;
         7:       pick = 64'hFFFF_FFFF;
         default: pick = 64'($urandom);
      endcase
      if (pick > 64'hFFFF_FFFF) pick = 64'hFFFF_FFFF;
      return pick[CAP_W-1:0];
   endfunction

   // mostly a first node that keeps the box inside, sometimes anything
   function automatic logic [START_W-1:0] pick_first(int whole, int span);
      if (span > 0 && whole >= span && whole <= MAX_AXIS_NODES && $urandom_range(0, 7) != 0)
         return START_W'($urandom_range(0, whole - span));
      return START_W'($urandom);
   endfunction

   task automatic run_nexts();
      int n;
      n = 0;
      while (!shadow_walk.done && n < NEXT_BUDGET) begin
         push(CMD_NEXT, START_W'($urandom), START_W'($urandom), START_W'($urandom),
              pick_capacity(shadow_walk), $urandom_range(0, 49) == 0);
         n++;
      end
      // now and then one more request, past the end of the box if it is done
      if ($urandom_range(0, 3) == 0)
         push(CMD_NEXT, START_W'($urandom), START_W'($urandom), START_W'($urandom),
              $urandom, 1'b0);
   endtask

   task automatic random_phase();
      int dim [3];
      int span [3];
      int nbv, k, t, runs;
      for (k = 0; k < 3; k++) begin
         case ($urandom_range(0, 9))
            0:       dim[k] = $urandom_range(1000, MAX_AXIS_NODES);
            1:       dim[k] = $urandom_range(1, MAX_AXIS_NODES);
            default: dim[k] = $urandom_range(1, 8);
         endcase
         // a full span merges with the next slower axis
         case ($urandom_range(0, 5))
            0, 1:    span[k] = dim[k];
            2:       span[k] = 1;
            default: span[k] = $urandom_range(1, (dim[k] < 4) ? dim[k] : 4);
         endcase
      end
      nbv = $urandom_range(1, MAX_NODE_BYTES);
      // now and then an out-of-range setting; starts reject it unless the node size cut to 7 bits fits
      if ($urandom_range(0, 19) == 0) begin
         k = $urandom_range(0, 2);
         case ($urandom_range(0, 5))
            0:       dim[k] = 0;
            1:       dim[k] = $urandom_range(MAX_AXIS_NODES + 1, 2047);
            2:       span[k] = 0;
            3:       span[k] = $urandom_range(MAX_AXIS_NODES + 1, 2047);
            4:       nbv = 0;
            default: nbv = $urandom_range(MAX_NODE_BYTES + 1, 2047);
         endcase
      end
      set_config(dim[0], dim[1], dim[2], span[0], span[1], span[2], nbv);
      // new registers must not disturb a transfer already under way
      if (!shadow_walk.done && $urandom_range(0, 3) == 0) run_nexts();
      runs = $urandom_range(1, 4);
      for (t = 0; t < runs; t++) begin
         push(CMD_START, pick_first(dim[0], span[0]), pick_first(dim[1], span[1]),
              pick_first(dim[2], span[2]), $urandom, $urandom_range(0, 49) == 0);
         run_nexts();
      end
   endtask

   // ---------------------------------------------------------------- request driver

   // a request is offered once req_wait has run down; a held request also
   // waits until every earlier response is back
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         in_flight = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            chunks_due.push_back(walk_chunk(live_walk, cur));
            in_flight++;
         end
         if (rsp_tvalid && rsp_tready) in_flight--;
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].hold && in_flight != 0)) begin
               cur = req_backlog.pop_front();
               req_tdata <= {2'b00, cur.capacity, cur.start_z, cur.start_y, cur.start_x};
               req_tuser <= cur.cmd;
               req_tvalid <= 1'b1;
               req_wait = req_idle ? $urandom_range(0, 3) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response monitor

   task automatic report(input string what, input chunk_type want, input chunk_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: want ofs %h size %h done %b err %b, got ofs %h size %h done %b err %b",
                  what, want.offset, want.size, want.done, want.err,
                  got.offset, got.size, got.done, got.err);
   endtask

   // a ready stall is drawn into rsp_wait after each response when rsp_idle is set
   always @(posedge clock) begin
      chunk_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{offset: rsp_tdata[OFS_W-1:0], size: rsp_tdata[OFS_W+SIZE_W-1:OFS_W],
                    done: rsp_tlast, err: rsp_tuser};
            if (chunks_due.size() == 0) begin
               report("response with no request waiting", '0, got);
            end else begin
               want = chunks_due.pop_front();
               if (got.offset !== want.offset || got.size !== want.size ||
                   got.done !== want.done || got.err !== want.err)
                  report("chunk mismatch", want, got);
            end
            rsp_wait = rsp_idle ? $urandom_range(0, 3) : 0;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("strided_region_chunk_generator_unit_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int base;
      live_walk = fresh_walker();
      shadow_walk = live_walk;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset registers: one 8-byte node; a next before any start is answered as done
      push(CMD_NEXT, '0, '0, '0, '1, 1'b0);
      push(CMD_START, '0, '0, '0, '0, 1'b0);
      push(CMD_NEXT, '1, '1, '1, '0, 1'b0);       // zero capacity
      push(CMD_NEXT, '0, '0, '0, 32'd7, 1'b0);    // one byte short of a node
      push(CMD_NEXT, '0, '0, '0, 32'd8, 1'b0);    // exactly the node, ends the box
      push(CMD_NEXT, '0, '0, '0, '1, 1'b0);       // after done

      // largest array, single node at the far corner: highest origin
      set_config(MAX_AXIS_NODES, MAX_AXIS_NODES, MAX_AXIS_NODES, 1, 1, 1, MAX_NODE_BYTES);
      push(CMD_START, '1, '1, '1, '0, 1'b0);
      push(CMD_NEXT, '0, '0, '0, '1, 1'b0);

      // box equal to the array: all axes fold into one run, odd node size
      set_config(4, 5, 6, 4, 5, 6, 3);
      push(CMD_START, '0, '0, '0, '0, 1'b0);
      push(CMD_NEXT, '0, '0, '0, 32'd100, 1'b0);  // partial run, cut to whole nodes
      push(CMD_NEXT, '0, '0, '0, 32'd2, 1'b0);
      push(CMD_NEXT, '0, '0, '0, '1, 1'b1);       // sender holds until all responses are in

      // boxes outside the array along one axis, and one touching the far edge
      set_config(8, 8, 8, 4, 4, 4, 8);
      push(CMD_START, 10'd5, '0, '0, '0, 1'b0);
      push(CMD_NEXT, '0, '0, '0, '1, 1'b0);
      push(CMD_START, '0, '0, 10'd4, '0, 1'b0);
      push(CMD_START, '0, 10'd5, '0, '0, 1'b0);

      // counts and node sizes out of range
      set_config(8, 0, 8, 4, 4, 4, 8);
      push(CMD_START, '0, '0, '0, '0, 1'b0);
      set_config(8, 8, 8, 4, 4, MAX_AXIS_NODES + 1, 8);
      push(CMD_START, '0, '0, '0, '0, 1'b0);
      set_config(2047, 8, 8, 4, 4, 4, 0);
      push(CMD_START, '0, '0, '0, '0, 1'b0);
      set_config(8, 8, 8, 4, 4, 4, MAX_NODE_BYTES + 1);
      push(CMD_START, '0, '0, '0, '0, 1'b0);

      base = posted;
      while (posted - base < RANDOM_ITEMS) random_phase();

      settle();
      if (mismatches == 0 && chunks_due.size() == 0)
         $display("strided_region_chunk_generator_unit_test: PASS");
      else
         $display("strided_region_chunk_generator_unit_test: FAIL");
      $finish;
   end

endmodule
